### rtl/text_console_cell_writer_defines.svh
// Assertion macros for the text console cell writer.
// Both take the label first and expect clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define CCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("console writer: property check failed");
`define CCW_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("console writer: forbidden condition seen");
`else
`define CCW_ASSERT(lbl, prop)
`define CCW_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/ccw_pkg.sv
`default_nettype none
package ccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  // Fixed field widths
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character and attribute codes
  localparam logic [7:0] CHAR_LF      = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

  // Request codes on req_type
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_COLOR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Operations decoded by the front
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_COLOR,
    OP_READ,
    OP_NOREAD
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [IDX_W-1:0] addr;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/ccw_front.sv
`default_nettype none
module ccw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [7:0]    char_code_i,
  input  logic [3:0]    fore_color_i,
  input  logic [3:0]    back_color_i,
  input  logic [4:0]    read_row_i,
  input  logic [6:0]    read_col_i,
  input  logic          back_ready_i,
  output logic          push_o,
  output ccw_pkg::cmd_t push_data_o,
  input  logic          push_ready_i
);
  import ccw_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Take an item when the back end is ready and the stage is empty or drains this cycle
  assign in_ready_o = back_ready_i && (!valid_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = valid_q && push_ready_i;
  assign push_data_o = cmd_q;

  // Classify the request
  always_comb begin
    cmd_d      = '0;
    cmd_d.ch   = char_code_i;
    cmd_d.attr = {back_color_i, fore_color_i};
    cmd_d.addr = IDX_W'(read_row_i) * IDX_W'(COLUMNS) + IDX_W'(read_col_i);
    case (req_e'(req_type_i))
      REQ_PUT: begin
        if (char_code_i inside {CHAR_LF, CHAR_CR}) cmd_d.op = OP_NEWLINE;
        else cmd_d.op = OP_PUT;
      end
      REQ_CLEAR: cmd_d.op = OP_CLEAR;
      REQ_COLOR: cmd_d.op = OP_COLOR;
      REQ_READ: begin
        if (int'(read_row_i) < ROWS && int'(read_col_i) < COLUMNS) cmd_d.op = OP_READ;
        else cmd_d.op = OP_NOREAD;
      end
      default: cmd_d.op = OP_NOREAD;
    endcase
  end

  // Hold the classified item until the queue takes it
  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (push_o) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_d;
  end

endmodule
`default_nettype wire

### rtl/ccw_fifo.sv
`default_nettype none
module ccw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccw_pkg::cmd_t push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output ccw_pkg::cmd_t pop_data_o,
  input  logic          pop_i
);
  import ccw_pkg::*;

  cmd_t                  slots_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (int'(count_q) != FIFO_DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(1);
    if (do_pop) rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(1);
    if (do_push && !do_pop) count_d = count_q + FIFO_CNT_W'(1);
    else if (!do_push && do_pop) count_d = count_q - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

### rtl/ccw_back.sv
`default_nettype none
module ccw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  ccw_pkg::cmd_t                cmd_i,
  output logic                         pop_o,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccw_pkg::CURSOR_W-1:0] cursor_index_o,
  output logic [ccw_pkg::CELL_W-1:0]   cell_value_o,
  output logic                         scrolled_o
);
  import ccw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [CELL_W-1:0]   fill_cell_q, fill_cell_d;
  logic                emit_end_q, emit_end_d;
  logic                scr_q, scr_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    dest_q, dest_d;
  logic [7:0]          attr_q, attr_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [CURSOR_W-1:0] out_idx_q, out_idx_d;
  logic [CELL_W-1:0]   out_cell_q, out_cell_d;
  logic                out_scr_q, out_scr_d;

  // Screen store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic              slot_free, emit, emit_scr, line_adv, last_row;
  logic [CELL_W-1:0] emit_cell;
  logic [IDX_W-1:0]  nl_idx;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_row  = (int'(row_q) == ROWS - 1);
  assign nl_idx    = idx_q + IDX_W'(COLUMNS) - IDX_W'(col_q);
  assign ready_o   = !(state_q == S_FILL && !emit_end_q);

  // Sequence commands, scroll copies and fill sweeps
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_cell_d = fill_cell_q;
    emit_end_d  = emit_end_q;
    scr_d       = scr_q;
    pend_d      = 1'b0;
    dest_d      = dest_q;
    attr_d      = attr_q;
    col_d       = col_q;
    row_d       = row_q;
    idx_d       = idx_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    emit        = 1'b0;
    emit_cell   = '0;
    emit_scr    = 1'b0;
    pop_o       = 1'b0;
    line_adv    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_PUT: begin
              we    = 1'b1;
              waddr = idx_q;
              wdata = {attr_q, cmd_i.ch};
              if (int'(col_q) == COLUMNS - 1) begin
                line_adv = 1'b1;
              end else begin
                col_d = col_q + COL_W'(1);
                idx_d = idx_q + IDX_W'(1);
                emit  = 1'b1;
              end
            end
            OP_NEWLINE: line_adv = 1'b1;
            OP_CLEAR: begin
              attr_d      = DEFAULT_ATTR;
              col_d       = '0;
              row_d       = '0;
              idx_d       = '0;
              fill_cell_d = {DEFAULT_ATTR, BLANK_CHAR};
              cnt_d       = '0;
              scr_d       = 1'b0;
              emit_end_d  = 1'b1;
              state_d     = S_FILL;
            end
            OP_COLOR: begin
              attr_d = cmd_i.attr;
              emit   = 1'b1;
            end
            OP_READ: begin
              re      = 1'b1;
              raddr   = cmd_i.addr;
              state_d = S_READ;
            end
            default: emit = 1'b1;
          endcase
          // Move to the next line, scrolling from the last row
          if (line_adv) begin
            col_d = '0;
            if (last_row) begin
              idx_d   = IDX_W'(CELLS - COLUMNS);
              cnt_d   = '0;
              scr_d   = 1'b1;
              state_d = S_SCROLL;
            end else begin
              row_d = row_q + ROW_W'(1);
              idx_d = nl_idx;
              emit  = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_cell = rdata_q;
        state_d   = S_IDLE;
      end
      S_SCROLL: begin
        // Read one row ahead, write the previous read back one row up
        if (cnt_q < IDX_W'(CELLS - COLUMNS)) begin
          re     = 1'b1;
          raddr  = cnt_q + IDX_W'(COLUMNS);
          pend_d = 1'b1;
          dest_d = cnt_q;
          cnt_d  = cnt_q + IDX_W'(1);
        end else begin
          fill_cell_d = {attr_q, BLANK_CHAR};
          emit_end_d  = 1'b1;
          state_d     = S_FILL;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = dest_q;
          wdata = rdata_q;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = fill_cell_q;
        if (int'(cnt_q) == CELLS - 1) begin
          state_d    = S_IDLE;
          emit_end_d = 1'b0;
          emit       = emit_end_q;
          emit_scr   = scr_q;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Load the result register, drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_idx_d   = CURSOR_W'(idx_d);
      out_cell_d  = emit_cell;
      out_scr_d   = emit_scr;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      fill_cell_q <= {DEFAULT_ATTR, BLANK_CHAR};
      emit_end_q  <= 1'b0;
      scr_q       <= 1'b0;
      pend_q      <= 1'b0;
      attr_q      <= DEFAULT_ATTR;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_cell_q <= fill_cell_d;
      emit_end_q  <= emit_end_d;
      scr_q       <= scr_d;
      pend_q      <= pend_d;
      attr_q      <= attr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q     <= dest_d;
    out_idx_q  <= out_idx_d;
    out_cell_q <= out_cell_d;
    out_scr_q  <= out_scr_d;
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_index_o = out_idx_q;
  assign cell_value_o   = out_cell_q;
  assign scrolled_o     = out_scr_q;

endmodule
`default_nettype wire

### rtl/text_console_cell_writer.sv
// Items pass front register, queue and result register; a read also passes the read register.
// Scroll: one cell copied per cycle, then the bottom row blanked.
// Clear: one blank cell written per cycle over the whole screen.
// Throughput: one simple item per cycle while results are taken; the back end works one item at a time.
// Reset: asynchronous, active low; a blanking pass over every cell follows,
// during which no item is taken.
`default_nettype none
`include "text_console_cell_writer_defines.svh"
module text_console_cell_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  fore_color_i,
  input  logic [3:0]  back_color_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_index_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);
  import ccw_pkg::*;

  logic push, push_ready, q_valid, q_pop, back_ready;
  cmd_t push_data, q_data;

  // Accept and classify
  ccw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .back_ready_i (back_ready),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Decouple front and back
  ccw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_i        (q_pop)
  );

  // Execute against the screen store
  ccw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_data),
    .pop_o          (q_pop),
    .ready_o        (back_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_index_o (cursor_index_o),
    .cell_value_o   (cell_value_o),
    .scrolled_o     (scrolled_o)
  );

  `CCW_ASSERT(a_cursor_range, out_valid_o |-> int'(cursor_index_o) < CELLS)
  `CCW_ASSERT(a_scroll_index, out_valid_o && scrolled_o |-> cursor_index_o == CURSOR_W'(CELLS - COLUMNS))
  `CCW_ASSERT_NEVER(a_pop_in_init, q_pop && !back_ready)

endmodule
`default_nettype wire
